// ===== hdl/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg: shared types for the key click / long-press detector
// Sample and event word layouts, key phase and event code enums,
// configuration register indexes.
// ----------------------------------------------------------------------------
package bcl_pkg;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_WAIT     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_DOWN       = 3'd0,
        EV_UP         = 3'd1,
        EV_SINGLE     = 3'd2,
        EV_DOUBLE     = 3'd3,
        EV_LONG_START = 3'd4,
        EV_LONG_HOLD  = 3'd5,
        EV_LONG_END   = 3'd6
    } event_code_t;

    typedef enum logic [2:0] {
        CFG_KEY_COUNT    = 3'd0,
        CFG_ACTIVE_LOW   = 3'd1,
        CFG_DEBOUNCE     = 3'd2,
        CFG_CLICK_MAX    = 3'd3,
        CFG_DOUBLE_GAP   = 3'd4,
        CFG_LONG_PRESS   = 3'd5,
        CFG_HOLD_IVL     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  key_index;
        logic        raw_level;
        logic [31:0] now_ms;
    } bcl_in_t;

    typedef struct packed {
        logic [2:0]  event_key;
        event_code_t event_code;
        logic [31:0] event_time_ms;
        logic        last_of_run;
    } bcl_out_t;

endpackage

// ===== hdl/button_click_long_press_detector_top.sv =====
// ----------------------------------------------------------------------------
// button_click_long_press_detector_top: per-key click and long-press detector
// Debounces key samples and reports down, up, single, double and long-press
// start / hold / end events for up to KEY_SLOTS keys.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one scan sample word per handshake (key index, pin level,
//   millisecond timestamp). m_* channel: event words, up to two per sample,
//   the last one of a sample flagged by last_of_run. cfg_* channel: register
//   writes, always ready; write only while the block is idle.
//   A sample is registered on acceptance and evaluated in the next cycle
//   against the key's state flip-flops; state and the two-entry event buffer
//   are written at the end of that cycle; the first event is driven from
//   the event buffer. One sample per cycle is sustained while events drain;
//   a sample with two events holds the output port for both, the rate being
//   set by the single event port. Samples yielding no event never wait.
//   When m_ready is low and the event buffer is occupied, it holds; a pending
//   sample with events waits in the input register and s_ready drops.
//   Reset: all keys released, times and counters zero, registers at their
//   defaults (8 keys, all active low, 20/300/300/1000/200 ms).
// ----------------------------------------------------------------------------
module button_click_long_press_detector_top #(
    parameter int KEY_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcl_pkg::bcl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bcl_pkg::bcl_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import bcl_pkg::*;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [5:0] SLOTS_W6 = 6'(KEY_SLOTS);

    logic [3:0]  key_count_reg;
    logic [7:0]  active_low_reg;
    logic [15:0] debounce_reg;
    logic [15:0] click_max_reg;
    logic [15:0] double_gap_reg;
    logic [15:0] long_press_reg;
    logic [15:0] hold_ivl_reg;

    logic        in_vld_reg;
    bcl_in_t     in_data_reg;

    phase_t      phase_reg   [KEY_SLOTS];
    logic [31:0] press_reg   [KEY_SLOTS];
    logic [31:0] release_reg [KEY_SLOTS];
    logic [31:0] last_ev_reg [KEY_SLOTS];
    logic [1:0]  clicks_reg  [KEY_SLOTS];
    logic        long_reg    [KEY_SLOTS];

    bcl_out_t    ev_reg [2];
    logic [1:0]  ev_cnt_reg;

    logic [5:0]     key_ext;
    logic           in_range;
    logic [IDX_W-1:0] idx;
    logic [31:0]    t;
    phase_t         ph;
    logic [31:0]    pt, rt, lt;
    logic [1:0]     cs, cs1;
    logic           la;
    logic           pressed;
    logic [31:0]    dur, dt, pd, gap;
    logic           start, dt_ok, click_ok, gap_ok, hold_due;

    phase_t         phase_next;
    logic [31:0]    press_next, release_next, last_ev_next;
    logic [1:0]     clicks_next;
    logic           long_next;
    logic [1:0]     n_ev;
    event_code_t    code0, code1;

    logic           pair_free, fire, upd, pop;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg  <= 4'd8;
            active_low_reg <= 8'hFF;
            debounce_reg   <= 16'd20;
            click_max_reg  <= 16'd300;
            double_gap_reg <= 16'd300;
            long_press_reg <= 16'd1000;
            hold_ivl_reg   <= 16'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_COUNT:  key_count_reg  <= cfg_data[3:0];
                CFG_ACTIVE_LOW: active_low_reg <= cfg_data[7:0];
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_CLICK_MAX:  click_max_reg  <= cfg_data;
                CFG_DOUBLE_GAP: double_gap_reg <= cfg_data;
                CFG_LONG_PRESS: long_press_reg <= cfg_data;
                CFG_HOLD_IVL:   hold_ivl_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // key state read
    assign key_ext  = {3'b000, in_data_reg.key_index};
    assign in_range = (key_ext < {2'b00, key_count_reg}) && (key_ext < SLOTS_W6);
    assign idx      = key_ext[IDX_W-1:0];
    assign t        = in_data_reg.now_ms;

    assign ph = phase_reg[idx];
    assign pt = press_reg[idx];
    assign rt = release_reg[idx];
    assign lt = last_ev_reg[idx];
    assign cs = clicks_reg[idx];
    assign la = long_reg[idx];

    assign pressed  = active_low_reg[in_data_reg.key_index] ? !in_data_reg.raw_level
                                                            : in_data_reg.raw_level;
    assign dur      = t - pt;
    assign dt       = pressed ? (t - pt) : (t - rt);
    assign pd       = rt - pt;
    assign gap      = t - lt;
    assign cs1      = cs + 2'd1;
    assign start    = !la && (dur >= {16'd0, long_press_reg});
    assign dt_ok    = dt >= {16'd0, debounce_reg};
    assign click_ok = pd <= {16'd0, click_max_reg};
    assign gap_ok   = gap >= {16'd0, double_gap_reg};
    assign hold_due = gap >= {16'd0, hold_ivl_reg};

    // next phase
    always_comb begin
        phase_next = ph;
        unique case (ph)
            PH_RELEASED: begin
                if (pressed) phase_next = PH_DEBOUNCE;
            end
            PH_PRESSED: begin
                if (!pressed) phase_next = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
                if (dt_ok) begin
                    if (pressed) begin
                        phase_next = PH_PRESSED;
                    end else if (click_ok && cs1 == 2'd1) begin
                        phase_next = PH_WAIT;
                    end else begin
                        phase_next = PH_RELEASED;
                    end
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    phase_next = PH_DEBOUNCE;
                end else if (gap_ok) begin
                    phase_next = PH_RELEASED;
                end
            end
            default: phase_next = ph;
        endcase
    end

    // events and per-key data
    always_comb begin
        n_ev         = 2'd0;
        code0        = EV_DOWN;
        code1        = EV_DOWN;
        press_next   = pt;
        release_next = rt;
        last_ev_next = lt;
        clicks_next  = cs;
        long_next    = la;
        unique case (ph)
            PH_RELEASED: begin
                if (pressed) begin
                    press_next   = t;
                    last_ev_next = t;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    release_next = t;
                    last_ev_next = t;
                end else if (start) begin
                    long_next = 1'b1;
                    code0     = EV_LONG_START;
                    n_ev      = 2'd1;
                    if (hold_ivl_reg == 16'd0) begin
                        code1 = EV_LONG_HOLD;
                        n_ev  = 2'd2;
                    end
                end else if (la && hold_due) begin
                    code0 = EV_LONG_HOLD;
                    n_ev  = 2'd1;
                end
            end
            PH_DEBOUNCE: begin
                if (dt_ok) begin
                    if (pressed) begin
                        if (cs != 2'd1) begin
                            code0       = EV_DOWN;
                            n_ev        = 2'd1;
                            clicks_next = 2'd0;
                        end
                        long_next = 1'b0;
                    end else begin
                        code0 = EV_UP;
                        n_ev  = 2'd1;
                        if (click_ok) begin
                            if (cs1 == 2'd1) begin
                                clicks_next = cs1;
                            end else begin
                                code1       = EV_DOUBLE;
                                n_ev        = 2'd2;
                                clicks_next = 2'd0;
                            end
                        end else if (la) begin
                            code1       = EV_LONG_END;
                            n_ev        = 2'd2;
                            long_next   = 1'b0;
                            clicks_next = 2'd0;
                        end else begin
                            clicks_next = 2'd0;
                        end
                    end
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    press_next = t;
                end else if (gap_ok) begin
                    code0       = EV_SINGLE;
                    n_ev        = 2'd1;
                    clicks_next = 2'd0;
                end
            end
            default: ;
        endcase
        if (n_ev != 2'd0) last_ev_next = t;
        if (!in_range) n_ev = 2'd0;
    end

    // handshake between sample register and event buffer
    assign pop       = m_valid && m_ready;
    assign pair_free = (ev_cnt_reg == 2'd0) || (ev_cnt_reg == 2'd1 && m_ready);
    assign fire      = in_vld_reg && ((n_ev == 2'd0) || pair_free);
    assign upd       = fire && in_range;

    // key state write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                phase_reg[i]   <= PH_RELEASED;
                press_reg[i]   <= 32'd0;
                release_reg[i] <= 32'd0;
                last_ev_reg[i] <= 32'd0;
                clicks_reg[i]  <= 2'd0;
                long_reg[i]    <= 1'b0;
            end
        end else if (upd) begin
            phase_reg[idx]   <= phase_next;
            press_reg[idx]   <= press_next;
            release_reg[idx] <= release_next;
            last_ev_reg[idx] <= last_ev_next;
            clicks_reg[idx]  <= clicks_next;
            long_reg[idx]    <= long_next;
        end
    end

    // event buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_cnt_reg <= 2'd0;
        end else if (fire && n_ev != 2'd0) begin
            ev_cnt_reg <= n_ev;
        end else if (pop) begin
            ev_cnt_reg <= ev_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && n_ev != 2'd0) begin
            ev_reg[0].event_key     <= in_data_reg.key_index;
            ev_reg[0].event_code    <= code0;
            ev_reg[0].event_time_ms <= t;
            ev_reg[0].last_of_run   <= (n_ev == 2'd1);
            ev_reg[1].event_key     <= in_data_reg.key_index;
            ev_reg[1].event_code    <= code1;
            ev_reg[1].event_time_ms <= t;
            ev_reg[1].last_of_run   <= 1'b1;
        end else if (pop) begin
            ev_reg[0] <= ev_reg[1];
        end
    end

    assign m_valid = (ev_cnt_reg != 2'd0);
    assign m_data  = ev_reg[0];

endmodule
